// File: hdl/assert_macros.svh
// Assertion helpers. Each macro expands to a labeled concurrent assertion
// clocked on the given clock and disabled while the active-low reset is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication.
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMP(label, clk, rst_n, ante, cons)
`define ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

// File: hdl/obrs_pkg.sv
package obrs_pkg;

    localparam int DEPTH_DEF = 64;

    localparam int CAP_W    = 7;
    localparam int DATA_W   = 8;
    localparam int REQ_W    = 2;
    localparam int STATUS_W = 2;
    localparam int POS_W    = 6;
    localparam int OCC_W    = 7;

    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 32;

    localparam logic [REQ_W-1:0] REQ_PUT    = 2'd0;
    localparam logic [REQ_W-1:0] REQ_GET    = 2'd1;
    localparam logic [REQ_W-1:0] REQ_SEARCH = 2'd2;
    localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OVERWRITE = 2'd2;

    // controller -> datapath
    typedef struct packed {
        logic latch_in;
        logic mem_rd_first;
        logic mem_rd_next;
        logic do_put;
        logic do_pop;
        logic do_clear;
        logic get_miss;
        logic search_hit;
        logic out_load;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic [REQ_W-1:0] req;
        logic             empty;
        logic             hit;
        logic             last;
        logic             out_free;
    } t_sts;

endpackage

// File: hdl/obrs_ctl.sv
module obrs_ctl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  obrs_pkg::t_sts  i_sts,
    output obrs_pkg::t_cmd  o_cmd
);
    import obrs_pkg::*;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_EXEC   = 2'd1;
    localparam logic [1:0] S_RDWAIT = 2'd2;
    localparam logic [1:0] S_SCAN   = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign s_tready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (s_tvalid) begin
                    o_cmd.latch_in = 1'b1;
                    n_state        = S_EXEC;
                end
            end
            S_EXEC: begin
                unique case (i_sts.req)
                    REQ_PUT: begin
                        if (i_sts.out_free) begin
                            o_cmd.do_put   = 1'b1;
                            o_cmd.out_load = 1'b1;
                            n_state        = S_IDLE;
                        end
                    end
                    REQ_GET: begin
                        if (!i_sts.empty) begin
                            o_cmd.mem_rd_first = 1'b1;
                            n_state            = S_RDWAIT;
                        end else if (i_sts.out_free) begin
                            o_cmd.get_miss = 1'b1;
                            o_cmd.out_load = 1'b1;
                            n_state        = S_IDLE;
                        end
                    end
                    REQ_SEARCH: begin
                        if (!i_sts.empty) begin
                            o_cmd.mem_rd_first = 1'b1;
                            n_state            = S_SCAN;
                        end else if (i_sts.out_free) begin
                            o_cmd.out_load = 1'b1;
                            n_state        = S_IDLE;
                        end
                    end
                    REQ_CLEAR: begin
                        if (i_sts.out_free) begin
                            o_cmd.do_clear = 1'b1;
                            o_cmd.out_load = 1'b1;
                            n_state        = S_IDLE;
                        end
                    end
                endcase
            end
            S_RDWAIT: begin
                if (i_sts.out_free) begin
                    o_cmd.do_pop   = 1'b1;
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_SCAN: begin
                // compare the fetched entry; fetch the next one on a miss that is not the last
                if (i_sts.hit) begin
                    if (i_sts.out_free) begin
                        o_cmd.search_hit = 1'b1;
                        o_cmd.out_load   = 1'b1;
                        n_state          = S_IDLE;
                    end
                end else if (i_sts.last) begin
                    if (i_sts.out_free) begin
                        o_cmd.out_load = 1'b1;
                        n_state        = S_IDLE;
                    end
                end else begin
                    o_cmd.mem_rd_next = 1'b1;
                end
            end
        endcase
    end

endmodule

// File: hdl/obrs_dp.sv
module obrs_dp #(
    parameter int DEPTH = obrs_pkg::DEPTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic [obrs_pkg::S_TDATA_W-1:0]     s_tdata,
    input  logic [obrs_pkg::REQ_W-1:0]         s_tuser,
    input  logic                               i_cfg_valid,
    input  logic [obrs_pkg::CAP_W-1:0]         i_cfg_data,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [obrs_pkg::M_TDATA_W-1:0]     m_tdata,
    input  obrs_pkg::t_cmd                     i_cmd,
    output obrs_pkg::t_sts                     o_sts
);
    import obrs_pkg::*;

    localparam int PW   = $clog2(DEPTH);
    localparam int CNTW = $clog2(DEPTH + 1);
    localparam logic [7:0] DEPTH8 = 8'(DEPTH);

    logic [DATA_W-1:0] mem [DEPTH];

    logic [REQ_W-1:0]    r_req;
    logic [DATA_W-1:0]   r_data;
    logic [CNTW-1:0]     r_cap;
    logic [PW-1:0]       r_wptr;
    logic [PW-1:0]       r_rptr;
    logic                r_full;
    logic [DATA_W-1:0]   r_rdata;
    logic [PW-1:0]       r_pos;
    logic [CNTW-1:0]     r_left;
    logic                r_out_valid;
    logic [M_TDATA_W-1:0] r_tdata;

    logic [PW-1:0]       n_wptr;
    logic [PW-1:0]       n_rptr;
    logic                n_full;
    logic [M_TDATA_W-1:0] n_tdata;

    logic [PW-1:0]       wstep;
    logic [PW-1:0]       rstep;
    logic [PW-1:0]       pstep;
    logic [PW-1:0]       rd_addr;
    logic [CNTW-1:0]     cnt_cur;
    logic [CNTW-1:0]     cnt_next;
    logic                empty_cur;
    logic                empty_next;
    logic [CNTW-1:0]     cap_clamped;
    logic [STATUS_W-1:0] res_status;

    function automatic logic [PW-1:0] step_ptr(input logic [PW-1:0] p,
                                               input logic [CNTW-1:0] cap);
        logic [CNTW-1:0] inc;
        inc = CNTW'(p) + CNTW'(1);
        return (inc >= cap) ? '0 : PW'(inc);
    endfunction

    function automatic logic [CNTW-1:0] ring_count(input logic [PW-1:0] w,
                                                   input logic [PW-1:0] r,
                                                   input logic f,
                                                   input logic [CNTW-1:0] cap);
        logic [CNTW-1:0] cnt;
        if (f) begin
            cnt = cap;
        end else if (w >= r) begin
            cnt = CNTW'(w) - CNTW'(r);
        end else begin
            cnt = cap + CNTW'(w) - CNTW'(r);
        end
        return cnt;
    endfunction

    // zero acts as one, anything above the ring size as the ring size
    always_comb begin
        if (i_cfg_data == '0) begin
            cap_clamped = CNTW'(1);
        end else if ({1'b0, i_cfg_data} > DEPTH8) begin
            cap_clamped = CNTW'(DEPTH);
        end else begin
            cap_clamped = CNTW'(i_cfg_data);
        end
    end

    assign wstep     = step_ptr(r_wptr, r_cap);
    assign rstep     = step_ptr(r_rptr, r_cap);
    assign pstep     = step_ptr(r_pos, r_cap);
    assign cnt_cur   = ring_count(r_wptr, r_rptr, r_full, r_cap);
    assign empty_cur = !r_full && (r_wptr == r_rptr);

    always_comb begin
        n_wptr = r_wptr;
        n_rptr = r_rptr;
        n_full = r_full;
        priority if (i_cfg_valid || i_cmd.do_clear) begin
            n_wptr = '0;
            n_rptr = '0;
            n_full = 1'b0;
        end else if (i_cmd.do_put) begin
            // a put into a full ring pushes out the oldest byte
            n_wptr = wstep;
            n_rptr = r_full ? rstep : r_rptr;
            n_full = (wstep == (r_full ? rstep : r_rptr));
        end else if (i_cmd.do_pop) begin
            n_rptr = rstep;
            n_full = 1'b0;
        end else begin
            n_wptr = r_wptr;
            n_rptr = r_rptr;
            n_full = r_full;
        end
    end

    assign cnt_next   = ring_count(n_wptr, n_rptr, n_full, r_cap);
    assign empty_next = !n_full && (n_wptr == n_rptr);

    always_comb begin
        priority if (i_cmd.do_put && r_full) begin
            res_status = ST_OVERWRITE;
        end else if (i_cmd.get_miss) begin
            res_status = ST_EMPTY;
        end else begin
            res_status = ST_OK;
        end
    end

    assign n_tdata = {6'b0,
                      empty_next,
                      n_full,
                      OCC_W'(cnt_next),
                      i_cmd.search_hit ? POS_W'(r_pos) : POS_W'(0),
                      i_cmd.search_hit,
                      res_status,
                      i_cmd.do_pop ? r_rdata : DATA_W'(0)};

    assign rd_addr = i_cmd.mem_rd_first ? r_rptr : pstep;

    always_ff @(posedge i_clk) begin
        if (i_cmd.do_put) begin
            mem[r_wptr] <= r_data;
        end
        if (i_cmd.mem_rd_first || i_cmd.mem_rd_next) begin
            r_rdata <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_in) begin
            r_req  <= s_tuser;
            r_data <= s_tdata;
        end
        if (i_cmd.mem_rd_first) begin
            r_pos  <= r_rptr;
            r_left <= cnt_cur;
        end else if (i_cmd.mem_rd_next) begin
            r_pos  <= pstep;
            r_left <= r_left - CNTW'(1);
        end
        if (i_cmd.out_load) begin
            r_tdata <= n_tdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap       <= CNTW'(DEPTH);
            r_wptr      <= '0;
            r_rptr      <= '0;
            r_full      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_cap <= cap_clamped;
            end
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_full <= n_full;
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = r_tdata;

    assign o_sts.req      = r_req;
    assign o_sts.empty    = empty_cur;
    assign o_sts.hit      = (r_rdata == r_data);
    assign o_sts.last     = (r_left == CNTW'(1));
    assign o_sts.out_free = !r_out_valid || m_tready;

endmodule

// File: hdl/overwriting_byte_ring_with_search.sv
// Byte ring buffer that overwrites its oldest entry when full, with search.
// Request channel (s_*): s_tuser carries the request kind (put, get, search,
// clear), s_tdata the byte to store or the byte sought. One result word per
// request leaves on the m_* channel. Capacity is written on the cfg channel,
// which is always ready; a write also empties the ring.
// Requests are handled one at a time: a word is taken only in the idle
// state. Put, clear and get on an empty ring load their result in the
// execute state; a get that pops first reads the storage (one memory read)
// and loads its result in the read-wait state. A search reads one stored
// entry per cycle from the oldest on, up to the first match (at most the
// occupancy). A new request is taken only after the result of the last one
// is loaded into the output register.
// Results sit in an output register; a finished result waits there while
// m_tready is low, and the next request may be accepted and worked on
// meanwhile until it needs that register. Reset (synchronous, active low)
// empties the ring, sets capacity to the full ring size and drops any
// pending result; stored bytes are not cleared.
`include "assert_macros.svh"

module overwriting_byte_ring_with_search #(
    parameter int DEPTH = obrs_pkg::DEPTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // request word
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [obrs_pkg::S_TDATA_W-1:0]     s_tdata,   // [7:0] data
    input  logic [obrs_pkg::REQ_W-1:0]         s_tuser,   // [1:0] req_type
    // result word
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [7:0] read_data, [9:8] status, [10] found, [16:11] found_position,
    // [23:17] occupancy, [24] is_full, [25] is_empty, [31:26] zero
    output logic [obrs_pkg::M_TDATA_W-1:0]     m_tdata,
    // capacity write
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [obrs_pkg::CAP_W-1:0]         i_cfg_data
);
    import obrs_pkg::*;

    t_cmd cmd;
    t_sts sts;

    assign o_cfg_ready = 1'b1;

    obrs_ctl u_ctl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .i_sts    (sts),
        .o_cmd    (cmd)
    );

    obrs_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .i_cmd       (cmd),
        .o_sts       (sts)
    );

    // one request in flight: no new word right after one is taken
    `ASSERT_NXT(a_one_in_flight, i_clk, i_rst_n, s_tvalid && s_tready, !s_tready)
    // a loaded result is always presented on the next cycle
    `ASSERT_NXT(a_load_presents, i_clk, i_rst_n, cmd.out_load, m_tvalid)
    // the scan only advances past an entry that did not match
    `ASSERT_IMP(a_scan_on_miss, i_clk, i_rst_n, cmd.mem_rd_next, !sts.hit && !sts.last)

endmodule

// File: tb/sv/overwriting_byte_ring_with_search_test.sv
module overwriting_byte_ring_with_search_test;
    import obrs_pkg::*;

    localparam int RING_SLOTS  = DEPTH_DEF;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE      = 6;
    localparam int SEG_LEN     = 48;
    localparam int N_PHASES    = 12;
    localparam int MAX_REPORTS = 30;

    // result word, [7:0] first
    typedef struct packed {
        logic [5:0]          pad;
        logic                is_empty;
        logic                is_full;
        logic [OCC_W-1:0]    occupancy;
        logic [POS_W-1:0]    position;
        logic                found;
        logic [STATUS_W-1:0] status;
        logic [DATA_W-1:0]   read_data;
    } t_ring_result;

    typedef enum int {MIX_PACK, MIX_FILL, MIX_DRAIN, MIX_EVEN} t_mix;

    class byte_ring_tracker;
        logic [DATA_W-1:0] slots [RING_SLOTS];
        logic [CAP_W-1:0]  capacity;
        int                wr_ptr;
        int                rd_ptr;
        bit                full;
        t_ring_result      awaited [$];
        int                errors;
        int                checked;
        int                overwrites;
        int                empty_gets;
        int                search_hits;
        int                search_misses;

        function new();
            foreach (slots[i]) slots[i] = '0;
            set_capacity(CAP_W'(RING_SLOTS));
        endfunction

        function void set_capacity(logic [CAP_W-1:0] v);
            capacity = v;
            wr_ptr = 0;
            rd_ptr = 0;
            full = 1'b0;
        endfunction

        function int cap_now();
            if (capacity == 0) return 1;
            if (capacity > RING_SLOTS) return RING_SLOTS;
            return capacity;
        endfunction

        function int advance(int p);
            return (p + 1 >= cap_now()) ? 0 : p + 1;
        endfunction

        function bit holds_nothing();
            return !full && wr_ptr == rd_ptr;
        endfunction

        function int fill_level();
            if (full) return cap_now();
            if (wr_ptr >= rd_ptr) return wr_ptr - rd_ptr;
            return cap_now() + wr_ptr - rd_ptr;
        endfunction

        // some byte currently held, for searches that should hit
        function logic [DATA_W-1:0] stored_byte();
            int p;
            int k;
            p = rd_ptr;
            k = $urandom_range(0, fill_level() - 1);
            repeat (k) p = advance(p);
            return slots[p];
        endfunction

        function void note_request(logic [REQ_W-1:0] req, logic [DATA_W-1:0] val);
            t_ring_result e;
            int n;
            int p;
            e = '0;
            case (req)
                REQ_PUT: begin
                    slots[wr_ptr] = val;
                    if (full) begin
                        rd_ptr = advance(rd_ptr);
                        e.status = ST_OVERWRITE;
                        overwrites++;
                    end
                    wr_ptr = advance(wr_ptr);
                    full = (wr_ptr == rd_ptr);
                end
                REQ_GET: begin
                    if (holds_nothing()) begin
                        e.status = ST_EMPTY;
                        empty_gets++;
                    end else begin
                        e.read_data = slots[rd_ptr];
                        rd_ptr = advance(rd_ptr);
                        full = 1'b0;
                    end
                end
                REQ_SEARCH: begin
                    n = fill_level();
                    p = rd_ptr;
                    for (int i = 0; i < n; i++) begin
                        if (slots[p] == val) begin
                            e.found = 1'b1;
                            e.position = p[POS_W-1:0];
                            break;
                        end
                        p = advance(p);
                    end
                    if (e.found) search_hits++;
                    else search_misses++;
                end
                default: begin
                    wr_ptr = 0;
                    rd_ptr = 0;
                    full = 1'b0;
                end
            endcase
            e.occupancy = OCC_W'(fill_level());
            e.is_full = full;
            e.is_empty = holds_nothing();
            awaited.push_back(e);
        endfunction

        function void flag(string field, int unsigned exp_v, int unsigned act_v);
            if (exp_v != act_v) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: %s mismatch: expected %0d, actual %0d",
                             $time, field, exp_v, act_v);
            end
        endfunction

        function void check_word(logic [M_TDATA_W-1:0] word);
            t_ring_result e;
            t_ring_result a;
            a = word;
            if (awaited.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: unexpected result word: expected none, actual %h",
                             $time, word);
                return;
            end
            e = awaited.pop_front();
            checked++;
            flag("read_data", e.read_data, a.read_data);
            flag("status", e.status, a.status);
            flag("found", e.found, a.found);
            flag("found_position", e.position, a.position);
            flag("occupancy", e.occupancy, a.occupancy);
            flag("is_full", e.is_full, a.is_full);
            flag("is_empty", e.is_empty, a.is_empty);
            flag("upper zero bits", e.pad, a.pad);
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [REQ_W-1:0]     s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CAP_W-1:0]     i_cfg_data = '0;

    byte_ring_tracker ring_sb = new();

    bit quiet;
    bit send_noisy;
    bit recv_noisy = 1'b1;
    bit hold_off;
    int stall_left;
    int cap_writes;

    logic [CAP_W-1:0] cap_plan [N_PHASES] =
        '{7'd64, 7'd1, 7'd127, 7'd2, 7'd7, 7'd65, 7'd0, 7'd33, 7'd64, 7'd5, 7'd16, 7'd64};

    overwriting_byte_ring_with_search dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (m_tvalid && m_tready) ring_sb.check_word(m_tdata);
    end

    // result side back-pressure
    always begin
        @(negedge i_clk);
        if ($urandom_range(0, 63) == 0) recv_noisy = ($urandom_range(0, 2) != 0);
        if (hold_off) begin
            m_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge i_clk);
            hold_off = 1'b0;
        end else if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left--;
        end else if (!quiet && recv_noisy && $urandom_range(0, 7) == 0) begin
            m_tready <= 1'b0;
            stall_left = $urandom_range(0, 15);
        end else begin
            m_tready <= 1'b1;
        end
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("timeout after %0d cycles", CYCLE_LIMIT);
        $display("overwriting_byte_ring_with_search_test: FAIL");
        $finish;
    end

    function automatic logic [DATA_W-1:0] pick_byte();
        case ($urandom_range(0, 3))
            0: return DATA_W'($urandom_range(0, 255));
            1: return DATA_W'($urandom_range(0, 3));
            2: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
            default: return 8'hA0 + DATA_W'($urandom_range(0, 3));
        endcase
    endfunction

    function automatic logic [REQ_W-1:0] pick_request(t_mix m);
        int r;
        int put_pct;
        int get_pct;
        int search_pct;
        r = $urandom_range(0, 99);
        case (m)
            MIX_PACK:  begin put_pct = 85; get_pct = 2;  search_pct = 12; end
            MIX_FILL:  begin put_pct = 60; get_pct = 10; search_pct = 28; end
            MIX_DRAIN: begin put_pct = 25; get_pct = 50; search_pct = 23; end
            default:   begin put_pct = 40; get_pct = 30; search_pct = 28; end
        endcase
        if (r < put_pct) return REQ_PUT;
        if (r < put_pct + get_pct) return REQ_GET;
        if (r < put_pct + get_pct + search_pct) return REQ_SEARCH;
        return REQ_CLEAR;
    endfunction

    // called at a falling edge, returns at a falling edge
    task automatic send_request(logic [REQ_W-1:0] req, logic [DATA_W-1:0] val);
        if (send_noisy && !quiet && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= req;
        s_tdata <= val;
        do @(posedge i_clk); while (!s_tready);
        ring_sb.note_request(req, val);
        @(negedge i_clk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (ring_sb.awaited.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_capacity(logic [CAP_W-1:0] v);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        ring_sb.set_capacity(v);
        cap_writes++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        logic [REQ_W-1:0]  req;
        logic [DATA_W-1:0] val;
        t_mix              mix;

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        send_noisy = 1'b1;

        // reset capacity: empty get, empty search, hits and misses, clear
        send_request(REQ_GET, 8'h00);
        send_request(REQ_SEARCH, 8'hFF);
        send_request(REQ_PUT, 8'h00);
        send_request(REQ_PUT, 8'hFF);
        send_request(REQ_PUT, 8'hA5);
        send_request(REQ_SEARCH, 8'hFF);
        send_request(REQ_SEARCH, 8'h3C);
        send_request(REQ_GET, 8'h00);
        send_request(REQ_CLEAR, 8'hFF);
        send_request(REQ_GET, 8'h00);

        // zero acts as a single slot
        write_capacity(7'd0);
        send_request(REQ_PUT, 8'h12);
        send_request(REQ_PUT, 8'h34);
        send_request(REQ_SEARCH, 8'h34);
        send_request(REQ_GET, 8'h00);
        send_request(REQ_GET, 8'h00);

        // wraparound with overwrite in a three-slot ring
        write_capacity(7'd3);
        send_request(REQ_PUT, 8'h01);
        send_request(REQ_PUT, 8'h02);
        send_request(REQ_PUT, 8'h03);
        send_request(REQ_PUT, 8'h04);
        send_request(REQ_SEARCH, 8'h04);
        send_request(REQ_SEARCH, 8'h01);
        send_request(REQ_GET, 8'h00);

        for (int ph = 0; ph < N_PHASES; ph++) begin
            quiet = (ph >= N_PHASES - 2);
            write_capacity(cap_plan[ph]);
            for (int seg = 0; seg < 3; seg++) begin
                if (seg == 0) mix = MIX_PACK;
                else if (seg == 1) mix = MIX_FILL;
                else mix = t_mix'($urandom_range(0, 3));
                send_noisy = ($urandom_range(0, 3) != 0);
                for (int k = 0; k < SEG_LEN; k++) begin
                    // long result-side hold while requests keep coming
                    if (ph == 0 && seg == 1 && k == 0) hold_off = 1'b1;
                    if (ph == 3 && seg == 1 && k == 24) drain();
                    req = pick_request(mix);
                    if (req == REQ_SEARCH && ring_sb.fill_level() > 0 &&
                        $urandom_range(0, 9) < 6)
                        val = ring_sb.stored_byte();
                    else
                        val = pick_byte();
                    send_request(req, val);
                end
            end
        end

        drain();
        $display("Checked %0d result words across %0d capacity writes, out-of-range values included.",
                 ring_sb.checked, cap_writes);
        $display("Saw %0d overwrites, %0d gets on an empty ring, %0d search hits, %0d misses.",
                 ring_sb.overwrites, ring_sb.empty_gets, ring_sb.search_hits,
                 ring_sb.search_misses);
        if (ring_sb.errors == 0 && ring_sb.awaited.size() == 0) begin
            $display("overwriting_byte_ring_with_search_test: PASS");
        end else begin
            $display("overwriting_byte_ring_with_search_test: FAIL");
        end
        $finish;
    end

endmodule

// File: sim.f
+incdir+hdl
hdl/obrs_pkg.sv
hdl/obrs_ctl.sv
hdl/obrs_dp.sv
hdl/overwriting_byte_ring_with_search.sv
tb/sv/overwriting_byte_ring_with_search_test.sv
